>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/qitr_pkg.sv
// ----------------------------------------------------------------------------
// qitr_pkg
// Widths, types and constants of the inertia tensor rotation pipeline.
// ----------------------------------------------------------------------------
package qitr_pkg;

   // Fraction bits of the quaternion products and of the rotation matrix.
   localparam int QPROD_FRAC = 28;
   localparam int RMAT_FRAC  = 20;

   localparam int Q_W     = 16;                 // quaternion component
   localparam int T_W     = 32;                 // tensor entry
   localparam int QP_W    = 2 * Q_W;            // quaternion product
   localparam int RAW_W   = QP_W + 2;           // matrix entry before rounding
   localparam int R_W     = RAW_W - (QPROD_FRAC - RMAT_FRAC);  // rotation entry
   localparam int RT_W    = R_W + T_W;          // product R * I
   localparam int MACC_W  = RT_W + 2;           // sum of three such products
   localparam int M_W     = MACC_W - RMAT_FRAC; // entry of M = R * I
   localparam int M_SPLIT = 19;                 // low part of M in the split multiply
   localparam int PH_W    = (M_W - M_SPLIT) + R_W;
   localparam int PL_W    = (M_SPLIT + 1) + R_W;
   localparam int WT_W    = M_W + R_W + 2;      // one term of M * R^T
   localparam int W_W     = WT_W - RMAT_FRAC;   // rounded world entry before saturation

   localparam int NUM_STAGES = 8;

   typedef logic signed [Q_W-1:0]    quat_type;
   typedef logic signed [T_W-1:0]    tens_type;
   typedef logic signed [QP_W-1:0]   qprod_type;
   typedef logic signed [RAW_W-1:0]  raw_type;
   typedef logic signed [R_W-1:0]    rmat_type;
   typedef logic signed [RT_W-1:0]   rt_type;
   typedef logic signed [MACC_W-1:0] macc_type;
   typedef logic signed [M_W-1:0]    mval_type;
   typedef logic signed [PH_W-1:0]   phigh_type;
   typedef logic signed [PL_W-1:0]   plow_type;
   typedef logic signed [WT_W-1:0]   wterm_type;
   typedef logic signed [W_W-1:0]    wval_type;

   // Index of the six unique tensor entries.
   localparam int T_XX = 0;
   localparam int T_XY = 1;
   localparam int T_XZ = 2;
   localparam int T_YY = 3;
   localparam int T_YZ = 4;
   localparam int T_ZZ = 5;

endpackage

>>> rtl/qitr_req_if.sv
// ----------------------------------------------------------------------------
// qitr_req_if
// Request channel: one body orientation and body-frame inverse inertia tensor.
// ----------------------------------------------------------------------------
interface qitr_req_if import qitr_pkg::*; ();

   logic     valid;
   logic     ready;
   quat_type quat_x;
   quat_type quat_y;
   quat_type quat_z;
   quat_type quat_w;
   tens_type tensor_xx;
   tens_type tensor_xy;
   tens_type tensor_xz;
   tens_type tensor_yy;
   tens_type tensor_yz;
   tens_type tensor_zz;
   logic     finite_mass;

   modport source (
      output valid, quat_x, quat_y, quat_z, quat_w,
             tensor_xx, tensor_xy, tensor_xz, tensor_yy, tensor_yz, tensor_zz,
             finite_mass,
      input  ready
   );

   modport sink (
      input  valid, quat_x, quat_y, quat_z, quat_w,
             tensor_xx, tensor_xy, tensor_xz, tensor_yy, tensor_yz, tensor_zz,
             finite_mass,
      output ready
   );

endinterface

>>> rtl/qitr_rsp_if.sv
// ----------------------------------------------------------------------------
// qitr_rsp_if
// Response channel: world-frame inverse inertia tensor of one body.
// ----------------------------------------------------------------------------
interface qitr_rsp_if import qitr_pkg::*; ();

   logic     valid;
   logic     ready;
   tens_type world_xx;
   tens_type world_xy;
   tens_type world_xz;
   tens_type world_yy;
   tens_type world_yz;
   tens_type world_zz;
   logic     updated;

   modport source (
      output valid, world_xx, world_xy, world_xz, world_yy, world_yz, world_zz,
             updated,
      input  ready
   );

   modport sink (
      input  valid, world_xx, world_xy, world_xz, world_yy, world_yz, world_zz,
             updated,
      output ready
   );

endinterface

>>> rtl/quaternion_inertia_tensor_rotate_core.sv
// ----------------------------------------------------------------------------
// quaternion_inertia_tensor_rotate_core
// Rotates a body-frame inverse inertia tensor into the world frame as
// R * I * R^T, with R built from the body's orientation quaternion.
// ----------------------------------------------------------------------------
// The core takes one item per clock cycle while the response side does not
// stall, and passes it through eight register stages: quaternion products,
// rotation matrix with rounding, the 27 products of R * I, their sums with
// rounding, the split products of M * R^T, recombination of the split halves,
// the final sums with rounding, and the saturating output register. Every
// stage has its own valid bit and loads whenever it is empty or its successor
// moves, so bubbles are squeezed out and a stalled response holds its item
// while earlier stages keep filling. The quaternion is used as given, without
// normalization. Bodies of infinite mass come out with all entries zero and
// updated low.
// ----------------------------------------------------------------------------
module quaternion_inertia_tensor_rotate_core import qitr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   qitr_req_if.sink    req_chan,
   qitr_rsp_if.source  rsp_chan
);

`include "assert_macros.svh"

   // Quaternion product slots.
   localparam int QP_XX = 0;
   localparam int QP_XY = 1;
   localparam int QP_XZ = 2;
   localparam int QP_XW = 3;
   localparam int QP_YY = 4;
   localparam int QP_YZ = 5;
   localparam int QP_YW = 6;
   localparam int QP_ZZ = 7;
   localparam int QP_ZW = 8;

   localparam raw_type   RAW_ONE   = raw_type'(1) <<< QPROD_FRAC;
   localparam raw_type   RAW_HALF  = raw_type'(1) <<< (QPROD_FRAC - RMAT_FRAC - 1);
   localparam macc_type  MACC_HALF = macc_type'(1) <<< (RMAT_FRAC - 1);
   localparam wterm_type WT_HALF   = wterm_type'(1) <<< (RMAT_FRAC - 1);
   localparam tens_type  SAT_MAX   = {1'b0, {(T_W-1){1'b1}}};
   localparam tens_type  SAT_MIN   = {1'b1, {(T_W-1){1'b0}}};

   // Symmetric tensor: position of entry (row, column) among the six stored.
   localparam logic [2:0] TIDX [3][3] = '{
      '{3'd0, 3'd1, 3'd2},
      '{3'd1, 3'd3, 3'd4},
      '{3'd2, 3'd4, 3'd5}
   };
   // Row and column of each returned world entry.
   localparam logic [1:0] ROW_SEL [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] COL_SEL [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

   // ---------------------------------------------------------------- control
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] fm_ff;
   logic [NUM_STAGES-1:0] fm_in;
   logic [NUM_STAGES-1:0] stage_en;

   // A stage loads when it is empty or when its content moves on.
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
      valid_in[0] = req_chan.valid;
      fm_in[0]    = req_chan.finite_mass;
      for (int s = 1; s < NUM_STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
         fm_in[s]    = fm_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            if (stage_en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
         if (stage_en[s]) begin
            fm_ff[s] <= fm_in[s];
         end
      end
   end

   assign req_chan.ready = stage_en[0];

   // ---------------------------------------------- stage 1: quaternion products
   qprod_type qp_ff  [9];
   qprod_type qp_in  [9];
   tens_type  tn1_ff [6];
   tens_type  tn1_in [6];

   always_comb begin
      qp_in[QP_XX] = req_chan.quat_x * req_chan.quat_x;
      qp_in[QP_XY] = req_chan.quat_x * req_chan.quat_y;
      qp_in[QP_XZ] = req_chan.quat_x * req_chan.quat_z;
      qp_in[QP_XW] = req_chan.quat_x * req_chan.quat_w;
      qp_in[QP_YY] = req_chan.quat_y * req_chan.quat_y;
      qp_in[QP_YZ] = req_chan.quat_y * req_chan.quat_z;
      qp_in[QP_YW] = req_chan.quat_y * req_chan.quat_w;
      qp_in[QP_ZZ] = req_chan.quat_z * req_chan.quat_z;
      qp_in[QP_ZW] = req_chan.quat_z * req_chan.quat_w;
      tn1_in[T_XX] = req_chan.tensor_xx;
      tn1_in[T_XY] = req_chan.tensor_xy;
      tn1_in[T_XZ] = req_chan.tensor_xz;
      tn1_in[T_YY] = req_chan.tensor_yy;
      tn1_in[T_YZ] = req_chan.tensor_yz;
      tn1_in[T_ZZ] = req_chan.tensor_zz;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         qp_ff  <= qp_in;
         tn1_ff <= tn1_in;
      end
   end

   // ------------------------------------------------ stage 2: rotation matrix
   rmat_type r2_ff  [3][3];
   rmat_type r2_in  [3][3];
   tens_type tn2_ff [6];

   always_comb begin
      raw_type raw [3][3];
      raw_type rnd;
      raw[0][0] = RAW_ONE - ((raw_type'(qp_ff[QP_YY]) + raw_type'(qp_ff[QP_ZZ])) <<< 1);
      raw[0][1] = (raw_type'(qp_ff[QP_XY]) - raw_type'(qp_ff[QP_ZW])) <<< 1;
      raw[0][2] = (raw_type'(qp_ff[QP_XZ]) + raw_type'(qp_ff[QP_YW])) <<< 1;
      raw[1][0] = (raw_type'(qp_ff[QP_XY]) + raw_type'(qp_ff[QP_ZW])) <<< 1;
      raw[1][1] = RAW_ONE - ((raw_type'(qp_ff[QP_XX]) + raw_type'(qp_ff[QP_ZZ])) <<< 1);
      raw[1][2] = (raw_type'(qp_ff[QP_YZ]) - raw_type'(qp_ff[QP_XW])) <<< 1;
      raw[2][0] = (raw_type'(qp_ff[QP_XZ]) - raw_type'(qp_ff[QP_YW])) <<< 1;
      raw[2][1] = (raw_type'(qp_ff[QP_YZ]) + raw_type'(qp_ff[QP_XW])) <<< 1;
      raw[2][2] = RAW_ONE - ((raw_type'(qp_ff[QP_XX]) + raw_type'(qp_ff[QP_YY])) <<< 1);
      // Round to nearest with ties upward: add half, keep the upper bits.
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            rnd          = raw[i][k] + RAW_HALF;
            r2_in[i][k]  = rnd[RAW_W-1:QPROD_FRAC-RMAT_FRAC];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         r2_ff  <= r2_in;
         tn2_ff <= tn1_ff;
      end
   end

   // --------------------------------------------------- stage 3: R * I products
   rt_type   rt3_ff [3][3][3];
   rt_type   rt3_in [3][3][3];
   rmat_type r3_ff  [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               rt3_in[i][j][k] = r2_ff[i][k] * tn2_ff[TIDX[k][j]];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         rt3_ff <= rt3_in;
         r3_ff  <= r2_ff;
      end
   end

   // ------------------------------------------------------ stage 4: M = R * I
   mval_type m4_ff [3][3];
   mval_type m4_in [3][3];
   rmat_type r4_ff [3][3];

   always_comb begin
      macc_type acc;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            acc = macc_type'(rt3_ff[i][j][0]) + macc_type'(rt3_ff[i][j][1])
                + macc_type'(rt3_ff[i][j][2]) + MACC_HALF;
            m4_in[i][j] = acc[MACC_W-1:RMAT_FRAC];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         m4_ff <= m4_in;
         r4_ff <= r3_ff;
      end
   end

   // ------------------------------------------- stage 5: split M * R^T products
   // Each entry of M is split into a signed high part and an unsigned low part
   // so that no single multiplier exceeds the width of the rotation entries.
   phigh_type ph5_ff [6][3];
   phigh_type ph5_in [6][3];
   plow_type  pl5_ff [6][3];
   plow_type  pl5_in [6][3];

   always_comb begin
      logic signed [M_W-M_SPLIT-1:0] m_hi;
      logic signed [M_SPLIT:0]       m_lo;
      for (int e = 0; e < 6; e++) begin
         for (int k = 0; k < 3; k++) begin
            m_hi          = $signed(m4_ff[ROW_SEL[e]][k][M_W-1:M_SPLIT]);
            m_lo          = $signed({1'b0, m4_ff[ROW_SEL[e]][k][M_SPLIT-1:0]});
            ph5_in[e][k]  = m_hi * r4_ff[COL_SEL[e]][k];
            pl5_in[e][k]  = m_lo * r4_ff[COL_SEL[e]][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         ph5_ff <= ph5_in;
         pl5_ff <= pl5_in;
      end
   end

   // ------------------------------------------------- stage 6: recombine halves
   wterm_type wt6_ff [6][3];
   wterm_type wt6_in [6][3];

   always_comb begin
      for (int e = 0; e < 6; e++) begin
         for (int k = 0; k < 3; k++) begin
            wt6_in[e][k] = (wterm_type'(ph5_ff[e][k]) <<< M_SPLIT)
                         + wterm_type'(pl5_ff[e][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         wt6_ff <= wt6_in;
      end
   end

   // ------------------------------------------------- stage 7: W = M * R^T sums
   wval_type w7_ff [6];
   wval_type w7_in [6];

   always_comb begin
      wterm_type acc;
      for (int e = 0; e < 6; e++) begin
         acc      = wt6_ff[e][0] + wt6_ff[e][1] + wt6_ff[e][2] + WT_HALF;
         w7_in[e] = acc[WT_W-1:RMAT_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         w7_ff <= w7_in;
      end
   end

   // ------------------------------------------- stage 8: saturate and register
   tens_type world_ff [6];
   tens_type world_in [6];

   always_comb begin
      for (int e = 0; e < 6; e++) begin
         // In range when every bit above the 32-bit sign agrees with it.
         if (!fm_ff[6]) begin
            world_in[e] = '0;
         end else if (&w7_ff[e][W_W-1:T_W-1] || ~|w7_ff[e][W_W-1:T_W-1]) begin
            world_in[e] = w7_ff[e][T_W-1:0];
         end else if (w7_ff[e][W_W-1]) begin
            world_in[e] = SAT_MIN;
         end else begin
            world_in[e] = SAT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         world_ff <= world_in;
      end
   end

   assign rsp_chan.valid    = valid_ff[NUM_STAGES-1];
   assign rsp_chan.world_xx = world_ff[T_XX];
   assign rsp_chan.world_xy = world_ff[T_XY];
   assign rsp_chan.world_xz = world_ff[T_XZ];
   assign rsp_chan.world_yy = world_ff[T_YY];
   assign rsp_chan.world_yz = world_ff[T_YZ];
   assign rsp_chan.world_zz = world_ff[T_ZZ];
   assign rsp_chan.updated  = fm_ff[NUM_STAGES-1];

   // ------------------------------------------------------------- assertions
   `ASSERT_IMPLIES(a_frozen_body_zero, clock, reset,
      rsp_chan.valid && !rsp_chan.updated,
      (rsp_chan.world_xx == '0) && (rsp_chan.world_xy == '0) && (rsp_chan.world_xz == '0) && (rsp_chan.world_yy == '0) && (rsp_chan.world_yz == '0) && (rsp_chan.world_zz == '0),
      "infinite-mass item returned a nonzero entry")
   `ASSERT_NEXT(a_mid_stage_holds, clock, reset,
      valid_ff[3] && !stage_en[3], valid_ff[3],
      "stalled item dropped from the middle of the pipeline")
   `ASSERT_NEXT(a_accept_enters, clock, reset,
      req_chan.valid && req_chan.ready, valid_ff[0],
      "accepted item did not enter the first stage")

endmodule

>>> sim/world_tensor_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_tensor_compare
// Watches both channels of the tensor rotation core. For every accepted body
// it computes the world-frame tensor R * I * R^T in wide fixed point (zero
// for infinite mass) and queues it. Every returned result is then compared
// entry by entry, and on its updated flag, with the oldest queued tensor.
// ----------------------------------------------------------------------------
module world_tensor_compare import qitr_pkg::*; (
   input  logic clock,
   input  logic reset,
   qitr_req_if  req_mon,
   qitr_rsp_if  rsp_mon,
   output int   fail_count,
   output int   outstanding,
   output int   results_seen,
   output int   saturated_seen,
   output int   massless_seen
);

   typedef logic signed [95:0] wide_type;

   typedef struct packed {
      logic [5:0][31:0] ent;
      logic             updated;
   } world_type;

   localparam wide_type SAT_HI = wide_type'(64'sd2147483647);
   localparam wide_type SAT_LO = -wide_type'(64'sd2147483648);

   world_type expected_world [$];
   string     entry_name [6] = '{"world_xx", "world_xy", "world_xz",
                                 "world_yy", "world_yz", "world_zz"};

   // Divide by 2^s, rounding to nearest with ties toward plus infinity.
   function automatic wide_type round_near(wide_type v, int s);
      return (v + (wide_type'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic world_type rotate_into_world(quat_type qx, quat_type qy,
                                                   quat_type qz, quat_type qw,
                                                   logic [5:0][31:0] body,
                                                   logic finite);
      wide_type  x, y, z, w, one, acc, v;
      wide_type  pxx, pxy, pxz, pxw, pyy, pyz, pyw, pzz, pzw;
      wide_type  raw [9];
      wide_type  r [3][3];
      wide_type  t [3][3];
      wide_type  m [3][3];
      int        i, j, k, e;
      int        row_of [6];
      int        col_of [6];
      world_type res;
      res = '0;
      if (!finite) return res;
      row_of = '{0, 0, 0, 1, 1, 2};
      col_of = '{0, 1, 2, 1, 2, 2};
      x = qx;
      y = qy;
      z = qz;
      w = qw;
      one = wide_type'(1) <<< QPROD_FRAC;
      pxx = x * x; pxy = x * y; pxz = x * z; pxw = x * w;
      pyy = y * y; pyz = y * z; pyw = y * w;
      pzz = z * z; pzw = z * w;
      raw[0] = one - 2 * (pyy + pzz);
      raw[1] = 2 * (pxy - pzw);
      raw[2] = 2 * (pxz + pyw);
      raw[3] = 2 * (pxy + pzw);
      raw[4] = one - 2 * (pxx + pzz);
      raw[5] = 2 * (pyz - pxw);
      raw[6] = 2 * (pxz - pyw);
      raw[7] = 2 * (pyz + pxw);
      raw[8] = one - 2 * (pxx + pyy);
      for (i = 0; i < 9; i++)
         r[i / 3][i % 3] = round_near(raw[i], QPROD_FRAC - RMAT_FRAC);

      // The body tensor is symmetric, so the lower half mirrors the upper.
      t[0][0] = $signed(body[T_XX]);
      t[0][1] = $signed(body[T_XY]);
      t[0][2] = $signed(body[T_XZ]);
      t[1][1] = $signed(body[T_YY]);
      t[1][2] = $signed(body[T_YZ]);
      t[2][2] = $signed(body[T_ZZ]);
      t[1][0] = t[0][1];
      t[2][0] = t[0][2];
      t[2][1] = t[1][2];

      for (i = 0; i < 3; i++) begin
         for (j = 0; j < 3; j++) begin
            acc = 0;
            for (k = 0; k < 3; k++)
               acc += r[i][k] * t[k][j];
            m[i][j] = round_near(acc, RMAT_FRAC);
         end
      end

      for (e = 0; e < 6; e++) begin
         acc = 0;
         for (k = 0; k < 3; k++)
            acc += m[row_of[e]][k] * r[col_of[e]][k];
         v = round_near(acc, RMAT_FRAC);
         if (v > SAT_HI)
            v = SAT_HI;
         else if (v < SAT_LO)
            v = SAT_LO;
         res.ent[e] = v[31:0];
      end
      res.updated = 1'b1;
      return res;
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%t world_tensor_compare: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : watch
      world_type        want, got;
      logic [5:0][31:0] body;
      bit               sat;
      int               e;
      if (!reset) begin
         // Results are checked before new bodies are queued, since a body
         // accepted at this edge cannot have its result out yet.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.ent[T_XX] = rsp_mon.world_xx;
            got.ent[T_XY] = rsp_mon.world_xy;
            got.ent[T_XZ] = rsp_mon.world_xz;
            got.ent[T_YY] = rsp_mon.world_yy;
            got.ent[T_YZ] = rsp_mon.world_yz;
            got.ent[T_ZZ] = rsp_mon.world_zz;
            got.updated   = rsp_mon.updated;
            results_seen++;
            if (expected_world.size() == 0) begin
               note_failure("result item arrived with no body outstanding");
            end else begin
               want = expected_world.pop_front();
               sat = 1'b0;
               for (e = 0; e < 6; e++) begin
                  if (got.ent[e] !== want.ent[e])
                     note_failure($sformatf("result %0d %s expected %h got %h",
                                            results_seen, entry_name[e],
                                            want.ent[e], got.ent[e]));
                  if (want.ent[e] == 32'h7FFF_FFFF || want.ent[e] == 32'h8000_0000)
                     sat = 1'b1;
               end
               if (got.updated !== want.updated)
                  note_failure($sformatf("result %0d updated expected %b got %b",
                                         results_seen, want.updated, got.updated));
               if (!want.updated)
                  massless_seen++;
               else if (sat)
                  saturated_seen++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            body[T_XX] = req_mon.tensor_xx;
            body[T_XY] = req_mon.tensor_xy;
            body[T_XZ] = req_mon.tensor_xz;
            body[T_YY] = req_mon.tensor_yy;
            body[T_YZ] = req_mon.tensor_yz;
            body[T_ZZ] = req_mon.tensor_zz;
            expected_world.insert(expected_world.size(),
                                  rotate_into_world(req_mon.quat_x, req_mon.quat_y,
                                                    req_mon.quat_z, req_mon.quat_w,
                                                    body, req_mon.finite_mass));
         end
      end
      outstanding = expected_world.size();
   end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives bodies into the inertia tensor rotation core: a directed set of
// rotations, extreme fields and infinite-mass bodies, then random bodies with
// mostly unit quaternions. Both channels idle at random, the response side
// holds off once long enough to back the pipeline up, and the checker beside
// the core compares every world tensor.
// ----------------------------------------------------------------------------
module tb_top;
   import qitr_pkg::*;

   typedef struct {
      quat_type qx, qy, qz, qw;
      tens_type txx, txy, txz, tyy, tyz, tzz;
      logic     finite_mass;
   } body_type;

   localparam quat_type Q_ONE  = 16'sd16384;
   localparam quat_type Q_HALF = 16'sd11585;  // cos of 45 degrees
   localparam quat_type Q_MIN  = 16'sh8000;
   localparam quat_type Q_MAX  = 16'sh7FFF;
   localparam tens_type T_MIN  = 32'sh8000_0000;
   localparam tens_type T_MAX  = 32'sh7FFF_FFFF;
   localparam tens_type T_UNIT = 32'sh0001_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int fail_count, outstanding, results_seen, saturated_seen, massless_seen;
   int directed_sent, random_sent, results_taken;
   bit sender_burst   = 1'b0;
   bit receiver_burst = 1'b0;
   bit hold_request   = 1'b0;

   body_type directed_bodies [$];

   qitr_req_if req_bus ();
   qitr_rsp_if rsp_bus ();

   quaternion_inertia_tensor_rotate_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   world_tensor_compare world_cmp (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .results_seen   (results_seen),
      .saturated_seen (saturated_seen),
      .massless_seen  (massless_seen)
   );

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("tb_top: done, errors");
      $finish;
   end

   function automatic body_type body_of(quat_type x, quat_type y, quat_type z, quat_type w,
                                        tens_type xx, tens_type xy, tens_type xz,
                                        tens_type yy, tens_type yz, tens_type zz,
                                        logic finite);
      body_type b;
      b.qx = x; b.qy = y; b.qz = z; b.qw = w;
      b.txx = xx; b.txy = xy; b.txz = xz; b.tyy = yy; b.tyz = yz; b.tzz = zz;
      b.finite_mass = finite;
      return b;
   endfunction

   function automatic void add_directed(body_type b);
      directed_bodies.insert(directed_bodies.size(), b);
   endfunction

   // Random orientation, normalized in real arithmetic and scaled to Q2.14.
   task automatic unit_quat(inout body_type b);
      real c [4];
      real n;
      int  i;
      do begin
         for (i = 0; i < 4; i++)
            c[i] = real'(int'($urandom_range(0, 65535))) - 32768.0;
         n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
      end while (n < 100.0);
      b.qx = quat_type'($rtoi(c[0] / n * 16384.0));
      b.qy = quat_type'($rtoi(c[1] / n * 16384.0));
      b.qz = quat_type'($rtoi(c[2] / n * 16384.0));
      b.qw = quat_type'($rtoi(c[3] / n * 16384.0));
   endtask

   // A plausible inverse inertia: positive diagonal, small coupling terms.
   function automatic void modest_tensor(inout body_type b);
      b.txx = $urandom_range(1, 1 << 22);
      b.tyy = $urandom_range(1, 1 << 22);
      b.tzz = $urandom_range(1, 1 << 22);
      b.txy = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      b.txz = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      b.tyz = int'($urandom_range(0, 1 << 21)) - (1 << 20);
   endfunction

   function automatic void wild_fields(inout body_type b);
      b.qx = quat_type'($urandom());
      b.qy = quat_type'($urandom());
      b.qz = quat_type'($urandom());
      b.qw = quat_type'($urandom());
      b.txx = tens_type'($urandom()); b.txy = tens_type'($urandom());
      b.txz = tens_type'($urandom()); b.tyy = tens_type'($urandom());
      b.tyz = tens_type'($urandom()); b.tzz = tens_type'($urandom());
   endfunction

   task automatic random_body(output body_type b);
      int sel;
      sel = $urandom_range(0, 19);
      b.finite_mass = 1'b1;
      if (sel < 8) begin
         unit_quat(b);
         modest_tensor(b);
      end else if (sel < 11) begin
         wild_fields(b);
         unit_quat(b);
      end else if (sel < 15) begin
         wild_fields(b);
         b.finite_mass = 1'($urandom_range(0, 1));
      end else if (sel < 17) begin
         wild_fields(b);
         b.finite_mass = 1'b0;
      end else begin
         // Non-unit quaternion: scaled, skewed transform.
         modest_tensor(b);
         b.qx = quat_type'(int'($urandom_range(0, 40000)) - 20000);
         b.qy = quat_type'(int'($urandom_range(0, 40000)) - 20000);
         b.qz = quat_type'(int'($urandom_range(0, 40000)) - 20000);
         b.qw = quat_type'(int'($urandom_range(0, 40000)) - 20000);
      end
   endtask

   task automatic send_body(input body_type b);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.quat_x      <= b.qx;
      req_bus.quat_y      <= b.qy;
      req_bus.quat_z      <= b.qz;
      req_bus.quat_w      <= b.qw;
      req_bus.tensor_xx   <= b.txx;
      req_bus.tensor_xy   <= b.txy;
      req_bus.tensor_xz   <= b.txz;
      req_bus.tensor_yy   <= b.tyy;
      req_bus.tensor_yz   <= b.tyz;
      req_bus.tensor_zz   <= b.tzz;
      req_bus.finite_mass <= b.finite_mass;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_random(int count);
      body_type b;
      int       n;
      for (n = 0; n < count; n++) begin
         if (n % 40 == 0)
            sender_burst = ($urandom_range(0, 2) == 0);
         random_body(b);
         send_body(b);
         random_sent++;
      end
   endtask

   // Response side: random stalls, stretches without any, and one long hold.
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (240) @(posedge clock);
            hold_request = 1'b0;
         end
         gap = receiver_burst ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         results_taken++;
         if (results_taken % 50 == 0)
            receiver_burst = ($urandom_range(0, 2) == 0);
      end
   end

   initial begin
      body_type b;
      req_bus.valid       <= 1'b0;
      req_bus.quat_x      <= '0;
      req_bus.quat_y      <= '0;
      req_bus.quat_z      <= '0;
      req_bus.quat_w      <= '0;
      req_bus.tensor_xx   <= '0;
      req_bus.tensor_xy   <= '0;
      req_bus.tensor_xz   <= '0;
      req_bus.tensor_yy   <= '0;
      req_bus.tensor_yz   <= '0;
      req_bus.tensor_zz   <= '0;
      req_bus.finite_mass <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Identity, simple rotations and the zero quaternion (R is then identity).
      add_directed(body_of(0, 0, 0, Q_ONE, T_UNIT, 0, 0, T_UNIT, 0, T_UNIT, 1));
      add_directed(body_of(0, 0, 0, Q_ONE, 32'sh0001_2345, -4660, 9000,
                           32'sh0002_0000, -77, 32'sh0003_0000, 1));
      add_directed(body_of(0, 0, Q_HALF, Q_HALF, T_UNIT, 32'sh2000, -32'sh1000,
                           32'sh0003_0000, 32'sh500, 32'sh0002_0000, 1));
      add_directed(body_of(Q_ONE, 0, 0, 0, T_UNIT, 32'sh1234, 32'sh4321,
                           32'sh0002_0000, -32'sh777, 32'sh0005_0000, 1));
      add_directed(body_of(0, Q_ONE, 0, 0, 32'sh0004_0000, -32'sh100, 32'sh200,
                           T_UNIT, 32'sh300, 32'sh0002_8000, 1));
      add_directed(body_of(0, 0, 0, 0, T_MAX, T_MIN, T_MAX, T_MIN, T_MAX, T_MIN, 1));
      add_directed(body_of(0, Q_HALF, 0, -Q_HALF, 0, 0, 0, 0, 0, 0, 1));
      // Extreme quaternions and tensors, some of which drive the world entries to saturation.
      add_directed(body_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                           T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, 1));
      add_directed(body_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                           T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, 1));
      add_directed(body_of(Q_MIN, 0, 0, 0, T_MAX, 0, 0, T_MAX, 0, T_MAX, 1));
      add_directed(body_of(0, 0, 0, Q_MIN, T_MIN, T_MAX, T_MIN, T_MAX, T_MIN, T_MAX, 1));
      add_directed(body_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, -1, 1, 1, -1, 1, 1));
      // Infinite mass bodies come back zeroed whatever they carry.
      add_directed(body_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                           T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, 0));
      add_directed(body_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                           T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, 0));
      // Alternating bit patterns so every input bit toggles early on.
      add_directed(body_of(16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555,
                           32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
                           32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555, 1));
      add_directed(body_of(16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA,
                           32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                           32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 1));
      // Matrix entries that land exactly halfway between two steps.
      add_directed(body_of(8, 8, 0, Q_ONE, T_UNIT, 32'sh8000, 0, T_UNIT, 0, T_UNIT, 1));
      add_directed(body_of(8, -8, 0, Q_ONE, T_UNIT, -32'sh8000, 0, T_UNIT, 0, T_UNIT, 1));

      foreach (directed_bodies[i]) begin
         send_body(directed_bodies[i]);
         directed_sent++;
      end
      drain();

      send_random(300);

      // Long response hold while the sender keeps offering items back to back,
      // so the pipeline fills and backs up into the request channel.
      hold_request = 1'b1;
      sender_burst = 1'b1;
      repeat (60) begin
         random_body(b);
         send_body(b);
         random_sent++;
      end
      drain();

      send_random(540);

      drain();
      repeat (20) @(posedge clock);
      $display("tb_top: sent %0d directed and %0d random bodies, checked %0d results",
               directed_sent, random_sent, results_seen);
      $display("tb_top: %0d results carried a saturated entry, %0d were infinite mass",
               saturated_seen, massless_seen);
      if (fail_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/qitr_pkg.sv
rtl/qitr_req_if.sv
rtl/qitr_rsp_if.sv
rtl/quaternion_inertia_tensor_rotate_core.sv
sim/world_tensor_compare.sv
sim/tb_top.sv
